[design/edmh_pkg.sv]
// Shared constants and types for the echo distance median block.
// No dependencies.
package edmh_pkg;

  localparam int unsigned FIELD_W = 13;
  localparam int unsigned WIDTH_W = 15;

  localparam longint unsigned US_PER_CM = 64'd58;
  localparam logic [WIDTH_W-1:0] MAX_WIDTH_US = 15'd29000;

  localparam logic [FIELD_W-1:0] SNAPSHOT_RESET = 13'd160;
  localparam logic [FIELD_W-1:0] RELEASE_RESET = 13'd320;

  typedef enum logic [0:0] {
    CFG_SNAPSHOT = 1'b0,
    CFG_RELEASE  = 1'b1
  } cfg_reg_e;

endpackage

[design/echo_distance_median_hysteresis.sv]
// Top level of the echo distance median block with hysteresis flag.
// Depends on edmh_pkg, edmh_conv and edmh_cell.
//
// One echo attempt is accepted per cycle unless the input stalls. Each attempt
// is converted to a distance in 1/2^FRACTION_BITS cm and registered; a valid
// one is then inserted into a chain of TRIES sorting cells. The attempt that
// closes a round picks the median out of the chain into a result stage, and
// the output stage applies the hysteresis thresholds. While a result waits at
// the output, the chain keeps taking attempts of the next round; only a
// closing attempt that finds the result stage still full stalls until it
// empties. Configuration writes are always ready.
module echo_distance_median_hysteresis #(
  parameter int unsigned TRIES = 5,
  parameter int unsigned FRACTION_BITS = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  edmh_pkg::cfg_reg_e           cfg_index_i,
  input  logic [edmh_pkg::FIELD_W-1:0] cfg_data_i,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [edmh_pkg::WIDTH_W-1:0] pulse_width_us_i,
  input  logic                         timed_out_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [edmh_pkg::FIELD_W-1:0] median_distance_o,
  output logic                         median_ok_o,
  output logic                         entered_snapshot_o,
  output logic                         left_reset_o,
  output logic                         waiting_now_o
);
  import edmh_pkg::*;

  localparam int unsigned DIST_W = 10 + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(TRIES + 1);
  localparam int unsigned IDX_W = (TRIES > 1) ? $clog2(TRIES) : 1;
  localparam int unsigned CMP_W = (DIST_W > FIELD_W) ? DIST_W : FIELD_W;

  // configuration
  logic [FIELD_W-1:0] snap_q, rel_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_q <= SNAPSHOT_RESET;
      rel_q  <= RELEASE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SNAPSHOT: snap_q <= cfg_data_i;
        CFG_RELEASE:  rel_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_v_q, s1_ok_q, s1_last_q;
  logic [DIST_W-1:0] s1_dist_q;
  logic r_v_q, r_ok_q;
  logic [DIST_W-1:0] r_med_q;
  logic out_v_q;
  logic out_can, r_move, r_can_load, s1_consume, in_acc;

  assign out_can    = !out_v_q || out_ready_i;
  assign r_move     = r_v_q && out_can;
  assign r_can_load = !r_v_q || r_move;
  assign s1_consume = s1_v_q && (!s1_last_q || r_can_load);
  assign in_ready_o = !s1_v_q || s1_consume;
  assign in_acc     = in_valid_i && in_ready_o;

  // stage 1: conversion and round position
  logic              conv_ok;
  logic [DIST_W-1:0] conv_dist;
  logic [CNT_W-1:0]  att_q;
  logic              att_last;

  edmh_conv #(
    .FRACTION_BITS(FRACTION_BITS),
    .DIST_W       (DIST_W)
  ) u_conv (
    .pulse_width_us_i(pulse_width_us_i),
    .timed_out_i     (timed_out_i),
    .reading_ok_o    (conv_ok),
    .dist_o          (conv_dist)
  );

  assign att_last = (att_q == CNT_W'(TRIES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      att_q  <= '0;
    end else begin
      if (in_acc) begin
        att_q <= att_last ? '0 : att_q + CNT_W'(1);
      end
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_consume) begin
        s1_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ok_q   <= conv_ok;
      s1_last_q <= att_last;
      s1_dist_q <= conv_dist;
    end
  end

  // stage 2: sorting chain
  logic              cell_load, cell_clear;
  logic [TRIES-1:0]  greater, occ;
  logic [DIST_W-1:0] cell_dist [TRIES];
  logic [DIST_W-1:0] next_dist [TRIES];
  logic [CNT_W-1:0]  cnt_q, cnt_new;
  logic [IDX_W-1:0]  med_idx;

  assign cell_load  = s1_consume && s1_ok_q;
  assign cell_clear = s1_consume && s1_last_q;

  for (genvar i = 0; i < TRIES; i++) begin : g_cell
    if (i == 0) begin : g_head
      edmh_cell #(.DIST_W(DIST_W)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .load_i        (cell_load),
        .clear_i       (cell_clear),
        .new_dist_i    (s1_dist_q),
        .prev_greater_i(1'b0),
        .prev_occ_i    (1'b0),
        .prev_dist_i   ('0),
        .greater_o     (greater[i]),
        .occ_o         (occ[i]),
        .dist_o        (cell_dist[i]),
        .next_dist_o   (next_dist[i])
      );
    end else begin : g_body
      edmh_cell #(.DIST_W(DIST_W)) u_cell (
        .clk_i         (clk_i),
        .rst_ni        (rst_ni),
        .load_i        (cell_load),
        .clear_i       (cell_clear),
        .new_dist_i    (s1_dist_q),
        .prev_greater_i(greater[i-1]),
        .prev_occ_i    (occ[i-1]),
        .prev_dist_i   (cell_dist[i-1]),
        .greater_o     (greater[i]),
        .occ_o         (occ[i]),
        .dist_o        (cell_dist[i]),
        .next_dist_o   (next_dist[i])
      );
    end
  end

  assign cnt_new = cnt_q + CNT_W'(s1_ok_q);
  assign med_idx = IDX_W'(cnt_new >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      r_v_q <= 1'b0;
    end else begin
      if (s1_consume) begin
        cnt_q <= s1_last_q ? '0 : cnt_new;
      end
      if (cell_clear) begin
        r_v_q <= 1'b1;
      end else if (r_move) begin
        r_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cell_clear) begin
      r_ok_q  <= (cnt_new != '0);
      r_med_q <= next_dist[med_idx];
    end
  end

  // stage 3: hysteresis and output
  logic wait_q, wait_d, entered, left;
  logic [CMP_W-1:0] med_c;

  assign med_c = CMP_W'(r_med_q);

  always_comb begin
    wait_d  = wait_q;
    entered = 1'b0;
    left    = 1'b0;
    if (r_ok_q) begin
      if (!wait_q) begin
        if (med_c < CMP_W'(snap_q)) begin
          entered = 1'b1;
          if (med_c >= CMP_W'(rel_q)) begin
            left = 1'b1;
          end else begin
            wait_d = 1'b1;
          end
        end
      end else if (med_c >= CMP_W'(rel_q)) begin
        left   = 1'b1;
        wait_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (r_move) begin
        wait_q  <= wait_d;
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_move) begin
      median_distance_o  <= r_ok_q ? FIELD_W'(r_med_q) : '0;
      median_ok_o        <= r_ok_q;
      entered_snapshot_o <= entered;
      left_reset_o       <= left;
      waiting_now_o      <= wait_d;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

[design/edmh_conv.sv]
// Width to distance converter: validity check and divide by 58 by reciprocal.
// Depends on edmh_pkg.
module edmh_conv #(
  parameter int unsigned FRACTION_BITS = 4,
  parameter int unsigned DIST_W = 10 + FRACTION_BITS
) (
  input  logic [edmh_pkg::WIDTH_W-1:0] pulse_width_us_i,
  input  logic                         timed_out_i,
  output logic                         reading_ok_o,
  output logic [DIST_W-1:0]            dist_o
);
  import edmh_pkg::*;

  localparam int unsigned NUM_W = WIDTH_W + FRACTION_BITS;
  localparam int unsigned SHIFT = NUM_W + 6;
  localparam int unsigned RECIP_W = SHIFT - 4;
  localparam int unsigned PROD_W = NUM_W + RECIP_W;
  localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + US_PER_CM - 64'd1) / US_PER_CM;

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;

  // ceil reciprocal with SHIFT = NUM_W + 6 is exact for every numerator
  assign num  = NUM_W'(pulse_width_us_i) << FRACTION_BITS;
  assign prod = PROD_W'(num) * PROD_W'(RECIP[RECIP_W-1:0]);
  assign dist_o = prod[SHIFT +: DIST_W];

  assign reading_ok_o = !timed_out_i && (pulse_width_us_i != '0) &&
                        (pulse_width_us_i < MAX_WIDTH_US);

endmodule

[design/edmh_cell.sv]
// One insertion cell of the sorted reading chain.
// Takes its left neighbor's entry when the new reading lands below it.
module edmh_cell #(
  parameter int unsigned DIST_W = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              clear_i,
  input  logic [DIST_W-1:0] new_dist_i,
  input  logic              prev_greater_i,
  input  logic              prev_occ_i,
  input  logic [DIST_W-1:0] prev_dist_i,
  output logic              greater_o,
  output logic              occ_o,
  output logic [DIST_W-1:0] dist_o,
  output logic [DIST_W-1:0] next_dist_o
);

  logic              occ_q, occ_d, occ_ins;
  logic [DIST_W-1:0] dist_q, dist_d;

  assign greater_o = !occ_q || (new_dist_i < dist_q);

  always_comb begin
    occ_ins = occ_q;
    dist_d  = dist_q;
    if (load_i && greater_o) begin
      if (prev_greater_i) begin
        occ_ins = prev_occ_i;
        dist_d  = prev_dist_i;
      end else begin
        occ_ins = 1'b1;
        dist_d  = new_dist_i;
      end
    end
    occ_d = clear_i ? 1'b0 : occ_ins;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign occ_o       = occ_q;
  assign dist_o      = dist_q;
  assign next_dist_o = dist_d;

endmodule
